// ===== hw/rtl/rational_arith_reduce_assert.svh =====
// Assertion macros for the checker file rar_checker.sv.
`ifndef RATIONAL_ARITH_REDUCE_ASSERT_SVH
`define RATIONAL_ARITH_REDUCE_ASSERT_SVH

// Checks that cons holds in the same cycle as ante.
`define RAR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that cons holds in the cycle after ante.
`define RAR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/rar_pkg.sv =====
package rar_pkg;

    localparam int OPERAND_WIDTH_DEF = 16;

    typedef enum logic [1:0] {
        FUNC_ADD = 2'd0,
        FUNC_SUB = 2'd1,
        FUNC_MUL = 2'd2,
        FUNC_DIV = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_FIX,
        ST_CHK,
        ST_GCD,
        ST_DIVN,
        ST_DIVD,
        ST_LOAD
    } state_t;

    typedef struct packed {
        logic       in_load;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       fix_en;
        logic       gcd_init;
        logic       gcd_step;
        logic       div_init;
        logic       div_den;
        logic       div_step;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic pass;
        logic gcd_done;
        logic div_done;
        logic out_free;
    } status_t;

endpackage

// ===== hw/rtl/rar_req_if.sv =====
interface rar_req_if #(
    parameter int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH_DEF
);
    logic                            valid;
    logic                            ready;
    logic [1:0]                      func;
    logic signed [OPERAND_WIDTH-1:0] a_num;
    logic [OPERAND_WIDTH-1:0]        a_den;
    logic signed [OPERAND_WIDTH-1:0] b_num;
    logic [OPERAND_WIDTH-1:0]        b_den;

    modport source (output valid, func, a_num, a_den, b_num, b_den, input ready);
    modport sink (input valid, func, a_num, a_den, b_num, b_den, output ready);
endinterface

// ===== hw/rtl/rar_rsp_if.sv =====
interface rar_rsp_if #(
    parameter int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH_DEF
);
    logic                              valid;
    logic                              ready;
    logic signed [2*OPERAND_WIDTH:0]   res_num;
    logic [2*OPERAND_WIDTH-1:0]        res_den;
    logic                              undefined;

    modport source (output valid, res_num, res_den, undefined, input ready);
    modport sink (input valid, res_num, res_den, undefined, output ready);
endinterface

// ===== hw/rtl/rar_ctrl.sv =====
module rar_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  rar_pkg::status_t status,
    output rar_pkg::cmd_t   cmd
);

    rar_pkg::state_t state_reg, state_next;
    logic [1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rar_pkg::ST_IDLE;
            cnt_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        cmd         = '0;
        cmd.mul_sel = cnt_reg;
        req_ready   = 1'b0;
        case (state_reg)
            rar_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.in_load = 1'b1;
                    cnt_next    = 2'd0;
                    state_next  = rar_pkg::ST_MUL;
                end
            end
            rar_pkg::ST_MUL:
            begin
                cmd.mul_en = 1'b1;
                cnt_next   = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    state_next = rar_pkg::ST_FIX;
                end
            end
            rar_pkg::ST_FIX:
            begin
                cmd.fix_en = 1'b1;
                state_next = rar_pkg::ST_CHK;
            end
            rar_pkg::ST_CHK:
            begin
                if (status.pass)
                begin
                    state_next = rar_pkg::ST_LOAD;
                end
                else
                begin
                    cmd.gcd_init = 1'b1;
                    state_next   = rar_pkg::ST_GCD;
                end
            end
            rar_pkg::ST_GCD:
            begin
                if (status.gcd_done)
                begin
                    cmd.div_init = 1'b1;
                    state_next   = rar_pkg::ST_DIVN;
                end
                else
                begin
                    cmd.gcd_step = 1'b1;
                end
            end
            rar_pkg::ST_DIVN:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                begin
                    state_next = rar_pkg::ST_DIVD;
                end
            end
            rar_pkg::ST_DIVD:
            begin
                if (!cmd.div_init && status.div_done)
                begin
                    cmd.div_step = 1'b1;
                    state_next   = rar_pkg::ST_LOAD;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            rar_pkg::ST_LOAD:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = rar_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rar_pkg::ST_IDLE;
            end
        endcase
        // The denominator division starts on the cycle after the numerator one ends.
        if (state_reg == rar_pkg::ST_DIVN && status.div_done)
        begin
            cmd.div_step = 1'b1;
        end
        if (state_reg == rar_pkg::ST_DIVD && cnt_reg == 2'd0)
        begin
            cmd.div_init = 1'b1;
            cmd.div_den  = 1'b1;
            cmd.div_step = 1'b0;
            cnt_next     = 2'd1;
            state_next   = rar_pkg::ST_DIVD;
        end
    end

endmodule

// ===== hw/rtl/rar_dp.sv =====
module rar_dp #(
    parameter int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    rar_req_if.sink         req,
    rar_rsp_if.source       rsp,
    input  rar_pkg::cmd_t   cmd,
    output rar_pkg::status_t status
);

    localparam int W  = OPERAND_WIDTH;
    localparam int NB = 2 * W + 2;
    localparam int MW = 2 * W + 1;
    localparam int KW = $clog2(MW + 1);
    localparam int CW = $clog2(MW);

    rar_pkg::func_t       op_reg;
    logic signed [W-1:0]  an_reg, bn_reg;
    logic [W-1:0]         ad_reg, bd_reg;
    logic signed [NB-1:0] prod_reg [4];
    logic signed [NB-1:0] num_reg, den_reg;
    logic [MW-1:0]        gx_reg, gy_reg, g_reg, q_reg, qn_reg;
    logic [MW:0]          rem_reg;
    logic [KW-1:0]        k_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 out_valid_reg;
    logic signed [MW-1:0] res_num_reg;
    logic [2*W-1:0]       res_den_reg;

    logic signed [W:0]    mul_a, mul_b;
    logic signed [NB-1:0] mul_p;
    logic signed [NB-1:0] num_next, den_next;
    logic [MW-1:0]        mag;
    logic [MW:0]          trial;
    logic [MW-1:0]        g_next;

    always_comb
    begin
        case (cmd.mul_sel)
            2'd0:    begin mul_a = {an_reg[W-1], an_reg}; mul_b = {1'b0, bd_reg}; end
            2'd1:    begin mul_a = {1'b0, ad_reg}; mul_b = {bn_reg[W-1], bn_reg}; end
            2'd2:    begin mul_a = {an_reg[W-1], an_reg}; mul_b = {bn_reg[W-1], bn_reg}; end
            default: begin mul_a = {1'b0, ad_reg}; mul_b = {1'b0, bd_reg}; end
        endcase
        mul_p = mul_a * mul_b;
    end

    always_comb
    begin
        case (op_reg)
            rar_pkg::FUNC_ADD: num_next = prod_reg[0] + prod_reg[1];
            rar_pkg::FUNC_SUB: num_next = prod_reg[0] - prod_reg[1];
            rar_pkg::FUNC_MUL: num_next = prod_reg[2];
            default:           num_next = prod_reg[0];
        endcase
        den_next = (op_reg == rar_pkg::FUNC_DIV) ? prod_reg[1] : prod_reg[3];
        if (den_next < 0)
        begin
            num_next = -num_next;
            den_next = -den_next;
        end
    end

    assign mag    = num_reg[NB-1] ? MW'(-num_reg) : MW'(num_reg);
    assign trial  = {rem_reg[MW-1:0], q_reg[MW-1]} - {1'b0, g_reg};
    assign g_next = gy_reg << k_reg;

    assign status.pass     = (num_reg == '0) || (den_reg == '0);
    assign status.gcd_done = (gx_reg == '0);
    assign status.div_done = (cnt_reg == CW'(MW - 1));
    assign status.out_free = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk)
    begin
        if (cmd.in_load)
        begin
            op_reg <= rar_pkg::func_t'(req.func);
            an_reg <= req.a_num;
            ad_reg <= req.a_den;
            bn_reg <= req.b_num;
            bd_reg <= req.b_den;
        end
        if (cmd.mul_en)
        begin
            prod_reg[cmd.mul_sel] <= mul_p;
        end
        if (cmd.fix_en)
        begin
            num_reg <= num_next;
            den_reg <= den_next;
        end
        if (cmd.gcd_init)
        begin
            gx_reg <= mag;
            gy_reg <= MW'(den_reg);
            k_reg  <= '0;
        end
        else if (cmd.gcd_step)
        begin
            if (!gx_reg[0] && !gy_reg[0])
            begin
                gx_reg <= gx_reg >> 1;
                gy_reg <= gy_reg >> 1;
                k_reg  <= k_reg + KW'(1);
            end
            else if (!gx_reg[0])
            begin
                gx_reg <= gx_reg >> 1;
            end
            else if (!gy_reg[0])
            begin
                gy_reg <= gy_reg >> 1;
            end
            else if (gx_reg >= gy_reg)
            begin
                gx_reg <= gx_reg - gy_reg;
            end
            else
            begin
                gy_reg <= gy_reg - gx_reg;
            end
        end
        if (cmd.div_init)
        begin
            rem_reg <= '0;
            cnt_reg <= '0;
            if (cmd.div_den)
            begin
                qn_reg <= q_reg;
                q_reg  <= MW'(den_reg);
            end
            else
            begin
                g_reg <= g_next;
                q_reg <= mag;
            end
        end
        else if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg + CW'(1);
            if (!trial[MW])
            begin
                rem_reg <= trial;
                q_reg   <= {q_reg[MW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[MW-1:0], q_reg[MW-1]};
                q_reg   <= {q_reg[MW-2:0], 1'b0};
            end
        end
        if (cmd.out_load)
        begin
            if (status.pass)
            begin
                res_num_reg <= MW'(num_reg);
                res_den_reg <= (2*W)'(den_reg);
            end
            else
            begin
                res_num_reg <= num_reg[NB-1] ? -qn_reg : qn_reg;
                res_den_reg <= (2*W)'(q_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.res_num   = res_num_reg;
    assign rsp.res_den   = res_den_reg;
    assign rsp.undefined = (res_den_reg == '0);

endmodule

// ===== hw/rtl/rational_arith_reduce.sv =====
// Rational arithmetic unit: adds, subtracts, multiplies or divides two fractions and
// reduces the result to lowest terms.
// The req channel carries one item: func, a_num, a_den, b_num and b_den. The rsp channel
// returns one item per request: res_num, res_den and undefined (set when res_den is zero).
// Items are taken one at a time; req.ready is high only while the unit is idle.
// When the raw numerator or denominator is zero, the pair passes unreduced. Otherwise the
// unit runs binary GCD steps on the magnitudes and then two restoring divisions by the
// GCD, one quotient bit per cycle, that yield the reduced numerator and denominator.
// One shared multiplier forms the four products in turn.
// The result sits in an output register, so the next request is taken while the
// previous result waits; a stalled rsp only holds up the unit once a new result is due.
// Reset clears the controller and the output valid flag; no item is in flight after it.
module rational_arith_reduce #(
    parameter int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH_DEF
) (
    input logic       clk,
    input logic       rst_n,
    rar_req_if.sink   req,
    rar_rsp_if.source rsp
);

    rar_pkg::cmd_t    cmd;
    rar_pkg::status_t status;
    logic             ctrl_ready;

    rar_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (ctrl_ready),
        .status    (status),
        .cmd       (cmd)
    );

    rar_dp #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .rsp    (rsp),
        .cmd    (cmd),
        .status (status)
    );

    assign req.ready = ctrl_ready;

endmodule

// ===== hw/rtl/rar_checker.sv =====
`include "rational_arith_reduce_assert.svh"

module rar_checker #(
    parameter int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [2*OPERAND_WIDTH:0]      res_num,
    input logic [2*OPERAND_WIDTH-1:0]    res_den,
    input logic                          undefined
);

    `RAR_ASSERT_IMP(a_undef_flag, rsp_valid, undefined == (res_den == '0), "undefined flag mismatch")
    `RAR_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(res_num), "rsp dropped")
    `RAR_ASSERT_NXT(a_no_early, req_valid && req_ready, !$rose(rsp_valid) && !req_ready, "too early")

endmodule

bind rational_arith_reduce rar_checker #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
) u_rar_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .res_num   (rsp.res_num),
    .res_den   (rsp.res_den),
    .undefined (rsp.undefined)
);
